// File: design/pwi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwi_pkg
// Shared widths, reset values, register indexes and types for the PID block
// with a conditional integration window.
// ----------------------------------------------------------------------------
package pwi_pkg;

    localparam int POS_W      = 24;
    localparam int FRAC_BITS  = 16;
    localparam int GAIN_W     = 8 + FRAC_BITS;
    localparam int STEP_W     = 10;
    localparam int WIN_W      = 24;
    localparam int LIMIT_W    = 40;
    localparam int DRIVE_W    = 32 + FRAC_BITS;
    localparam int ACC_W      = DRIVE_W;

    localparam int ERR_W      = POS_W + 1;
    localparam int DIFF_W     = POS_W + 2;
    localparam int ACC_HALF   = ACC_W / 2;
    localparam int ACC_HI_W   = ACC_W - ACC_HALF;
    localparam int MA_W       = (DIFF_W > ACC_HI_W) ? DIFF_W : ACC_HI_W;
    localparam int MB_W       = GAIN_W;
    localparam int MP_W       = MA_W + MB_W;
    localparam int PMAG_W     = ERR_W + GAIN_W;
    localparam int INCR_W     = ERR_W + STEP_W;
    localparam int DNUM_W     = DIFF_W + GAIN_W;
    localparam int DIV_W      = DNUM_W + (DNUM_W % 2);
    localparam int DIV_STEPS  = DIV_W / 2;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);
    localparam int LO_PW      = ACC_HALF + GAIN_W;
    localparam int HI_PW      = ACC_HI_W + GAIN_W;
    localparam int ITOT_W     = ACC_W + GAIN_W;
    localparam int CAP_LOG    = 60;
    localparam int IMAG_W     = CAP_LOG + 1;
    localparam int SUM_W      = IMAG_W + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIMIT_W;

    localparam logic [IMAG_W-1:0] TERM_CAP = IMAG_W'(1) << CAP_LOG;

    localparam logic [GAIN_W-1:0]  GAIN_RST  = '0;
    localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(20);
    localparam logic [WIN_W-1:0]   MAXW_RST  = WIN_W'(20);
    localparam logic [WIN_W-1:0]   MINW_RST  = WIN_W'(5);
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(65);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP,
        REG_KI,
        REG_KD,
        REG_STEP,
        REG_MAXW,
        REG_MINW,
        REG_LIMIT
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [STEP_W-1:0]  step;
        logic [WIN_W-1:0]   max_win;
        logic [WIN_W-1:0]   min_win;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

    typedef enum logic [2:0] {
        MSEL_ERR_KP,
        MSEL_ERR_STEP,
        MSEL_DIFF_KD,
        MSEL_ACC_LO,
        MSEL_ACC_HI
    } msel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_MP,
        S_MI,
        S_MD,
        S_AMAG,
        S_ILO,
        S_IHI,
        S_ISUM,
        S_DIV,
        S_SUM1,
        S_SUM2
    } state_t;

    typedef struct packed {
        logic  capture;
        logic  pre;
        logic  take_p;
        logic  acc_add;
        logic  acc_clamp;
        logic  div_start;
        logic  acc_mag;
        logic  take_ilo;
        logic  take_isum;
        logic  sum1;
        logic  load_out;
        msel_t msel;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } dp_stat_t;

endpackage

// File: design/pid_with_integral_window_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_with_integral_window_unit
// PID controller with a conditional integration window and saturated output.
// ----------------------------------------------------------------------------
//  channel | signals                                   | beat
//  --------+-------------------------------------------+--------------------
//  in      | in_valid, in_ready, measured, target      | one sample
//  out     | out_valid, out_ready, drive               | one drive value
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
//  The serial divider (two quotient bits per cycle) forms the derivative term.
//  in_ready is high only while the sequencer is idle.
//  A finished drive value waits in the output register while the next
//  sample is accepted; the sequencer stalls at the end if it is still held.
//  Asynchronous active-low reset; cfg_ready is always high.
// ----------------------------------------------------------------------------
module pid_with_integral_window_unit
    import pwi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [POS_W-1:0]   measured,
    input  logic signed [POS_W-1:0]   target,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DRIVE_W-1:0] drive,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    pwi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pwi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pwi_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .measured  (measured),
        .target    (target),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive)
    );

endmodule

// File: design/pwi_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwi_cfg
// Configuration register file: gains, loop period, window and integral limit.
// ----------------------------------------------------------------------------
module pwi_cfg
    import pwi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp      <= GAIN_RST;
            cfg_reg.ki      <= GAIN_RST;
            cfg_reg.kd      <= GAIN_RST;
            cfg_reg.step    <= STEP_RST;
            cfg_reg.max_win <= MAXW_RST;
            cfg_reg.min_win <= MINW_RST;
            cfg_reg.limit   <= LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KP:    cfg_reg.kp      <= cfg_data[GAIN_W-1:0];
                REG_KI:    cfg_reg.ki      <= cfg_data[GAIN_W-1:0];
                REG_KD:    cfg_reg.kd      <= cfg_data[GAIN_W-1:0];
                REG_STEP:  cfg_reg.step    <= cfg_data[STEP_W-1:0];
                REG_MAXW:  cfg_reg.max_win <= cfg_data[WIN_W-1:0];
                REG_MINW:  cfg_reg.min_win <= cfg_data[WIN_W-1:0];
                REG_LIMIT: cfg_reg.limit   <= cfg_data[LIMIT_W-1:0];
                default:   ;
            endcase
        end
    end

endmodule

// File: design/pwi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwi_div
// Restoring divider, two quotient bits per cycle, for the derivative term.
// ----------------------------------------------------------------------------
module pwi_div
    import pwi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  num,
    input  logic [STEP_W-1:0] dvs,
    output logic              busy,
    output logic [DIV_W-1:0]  quot
);

    logic              busy_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  quo_next;
    logic [STEP_W-1:0] rem_reg;
    logic [STEP_W-1:0] rem_next;
    logic [STEP_W-1:0] dvs_reg;

    assign busy = busy_reg;
    assign quot = quo_reg;

    always_comb
    begin : div_step
        logic [STEP_W:0]   trial;
        logic [STEP_W-1:0] r;
        logic [DIV_W-1:0]  q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            trial = {r, q[DIV_W-1]};
            q     = {q[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
                q[0]  = 1'b1;
            end
            r = trial[STEP_W-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DCNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            dvs_reg <= dvs;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // partial remainder stays below the divisor while the divider is busy
    a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dvs_reg))
        else $error("divider remainder out of range");

endmodule

// File: design/pwi_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwi_dp
// Datapath: error, window test, shared multiplier, integral update and clamp,
// derivative division, term sum with saturation and the output register.
// ----------------------------------------------------------------------------
module pwi_dp
    import pwi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  dp_cmd_t                   cmd,
    output dp_stat_t                  stat,
    input  logic signed [POS_W-1:0]   measured,
    input  logic signed [POS_W-1:0]   target,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DRIVE_W-1:0] drive
);

    localparam int WCMP_W = (ERR_W > WIN_W) ? ERR_W : WIN_W;

    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ERR_W-1:0]   err_next;
    logic [ERR_W-1:0]          err_mag_reg;
    logic [ERR_W-1:0]          err_mag_next;
    logic                      err_neg_reg;
    logic signed [ERR_W-1:0]   last_err_reg;
    logic                      win_reg;
    logic                      win_next;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [DIFF_W-1:0]  diff_next;
    logic [DIFF_W-1:0]         diff_mag_reg;
    logic [DIFF_W-1:0]         diff_mag_next;
    logic                      diff_neg_reg;

    logic [MA_W-1:0]           mul_a;
    logic [MB_W-1:0]           mul_b;
    logic [MP_W-1:0]           prod_reg;

    logic [PMAG_W-1:0]         p_mag_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_add_next;
    logic signed [ACC_W-1:0]   acc_clamp_next;
    logic signed [ACC_W-1:0]   lim_ext;
    logic [ACC_W:0]            acc_sum;
    logic [ACC_W:0]            inc_ext;
    logic [ACC_W-1:0]          acc_sat;
    logic [ACC_W-1:0]          acc_mag_reg;
    logic [ACC_W-1:0]          acc_mag_next;
    logic                      acc_neg_reg;
    logic [LO_PW-1:0]          ilo_reg;
    logic [ITOT_W-1:0]         itot;
    logic [IMAG_W-1:0]         i_mag_reg;
    logic [IMAG_W-1:0]         i_mag_next;

    logic                      div_busy;
    logic [DIV_W-1:0]          quot;
    logic [STEP_W-1:0]         dvs;

    logic [SUM_W-1:0]          p_ext;
    logic [SUM_W-1:0]          i_ext;
    logic [SUM_W-1:0]          d_ext;
    logic [SUM_W-1:0]          sp;
    logic [SUM_W-1:0]          si;
    logic [SUM_W-1:0]          sd;
    logic [SUM_W-1:0]          pi_reg;
    logic [SUM_W-1:0]          total;
    logic [SUM_W-DRIVE_W:0]    total_hi;
    logic [DRIVE_W-1:0]        drive_next;
    logic [DRIVE_W-1:0]        drive_reg;
    logic                      out_valid_reg;

    // error and its magnitude
    assign err_next     = $signed({target[POS_W-1], target})
                        - $signed({measured[POS_W-1], measured});
    assign err_mag_next = err_next[ERR_W-1] ? (~err_next + 1'b1) : err_next;

    assign win_next = !((WCMP_W'(err_mag_reg) > WCMP_W'(cfg.max_win))
                     || (WCMP_W'(err_mag_reg) < WCMP_W'(cfg.min_win)));
    assign diff_next     = $signed({err_reg[ERR_W-1], err_reg})
                         - $signed({last_err_reg[ERR_W-1], last_err_reg});
    assign diff_mag_next = diff_reg[DIFF_W-1] ? (~diff_reg + 1'b1) : diff_reg;

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.msel)
            MSEL_ERR_KP:
            begin
                mul_a = MA_W'(err_mag_reg);
                mul_b = cfg.kp;
            end
            MSEL_ERR_STEP:
            begin
                mul_a = MA_W'(err_mag_reg);
                mul_b = MB_W'(cfg.step);
            end
            MSEL_DIFF_KD:
            begin
                mul_a = MA_W'(diff_mag_reg);
                mul_b = cfg.kd;
            end
            MSEL_ACC_LO:
            begin
                mul_a = MA_W'(acc_mag_reg[ACC_HALF-1:0]);
                mul_b = cfg.ki;
            end
            MSEL_ACC_HI:
            begin
                mul_a = MA_W'(acc_mag_reg[ACC_W-1:ACC_HALF]);
                mul_b = cfg.ki;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // integral update, saturated at the register range, zero outside the window
    assign inc_ext = (ACC_W + 1)'(prod_reg[INCR_W-1:0]);
    assign acc_sum = err_neg_reg ? ({acc_reg[ACC_W-1], acc_reg} - inc_ext)
                                 : ({acc_reg[ACC_W-1], acc_reg} + inc_ext);
    always_comb
    begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                     : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end
    assign acc_add_next = win_reg ? $signed(acc_sat) : '0;

    assign lim_ext        = $signed(ACC_W'(cfg.limit));
    assign acc_clamp_next = (acc_reg > lim_ext) ? lim_ext : acc_reg;
    assign acc_mag_next   = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;

    // integral term magnitude, capped
    assign itot = ITOT_W'(ilo_reg) + (ITOT_W'(prod_reg[HI_PW-1:0]) << ACC_HALF);
    assign i_mag_next = (itot > ITOT_W'(TERM_CAP)) ? TERM_CAP : itot[IMAG_W-1:0];

    // derivative divisor, zero period divides by one
    assign dvs = (cfg.step == '0) ? STEP_W'(1) : cfg.step;

    pwi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (DIV_W'(prod_reg[DNUM_W-1:0])),
        .dvs   (dvs),
        .busy  (div_busy),
        .quot  (quot)
    );

    // signed terms and final sum, saturated to the drive width
    assign p_ext = SUM_W'(p_mag_reg);
    assign i_ext = SUM_W'(i_mag_reg);
    assign d_ext = SUM_W'(quot);
    assign sp    = err_neg_reg  ? (~p_ext + 1'b1) : p_ext;
    assign si    = acc_neg_reg  ? (~i_ext + 1'b1) : i_ext;
    assign sd    = diff_neg_reg ? (~d_ext + 1'b1) : d_ext;
    assign total    = pi_reg + sd;
    assign total_hi = total[SUM_W-1:DRIVE_W-1];
    always_comb
    begin
        if ((total_hi == '0) || (total_hi == '1))
        begin
            drive_next = total[DRIVE_W-1:0];
        end
        else
        begin
            drive_next = total[SUM_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}}
                                        : {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg  <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.pre)
            begin
                last_err_reg <= err_reg;
            end
            if (cmd.acc_add)
            begin
                acc_reg <= acc_add_next;
            end
            else if (cmd.acc_clamp)
            begin
                acc_reg <= acc_clamp_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= MP_W'(mul_a) * MP_W'(mul_b);
        if (cmd.capture)
        begin
            err_reg     <= err_next;
            err_mag_reg <= err_mag_next;
            err_neg_reg <= err_next[ERR_W-1];
        end
        if (cmd.pre)
        begin
            win_reg  <= win_next;
            diff_reg <= diff_next;
        end
        if (cmd.take_p)
        begin
            p_mag_reg    <= prod_reg[PMAG_W-1:0];
            diff_mag_reg <= diff_mag_next;
            diff_neg_reg <= diff_reg[DIFF_W-1];
        end
        if (cmd.acc_mag)
        begin
            acc_mag_reg <= acc_mag_next;
            acc_neg_reg <= acc_reg[ACC_W-1];
        end
        if (cmd.take_ilo)
        begin
            ilo_reg <= prod_reg[LO_PW-1:0];
        end
        if (cmd.take_isum)
        begin
            i_mag_reg <= i_mag_next;
        end
        if (cmd.sum1)
        begin
            pi_reg <= sp + si;
        end
        if (cmd.load_out)
        begin
            drive_reg <= drive_next;
        end
    end

    assign stat.div_busy = div_busy;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign drive         = $signed(drive_reg);

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    a_acc_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_clamp |=> (acc_reg <= lim_ext))
        else $error("integral above limit after clamp");

endmodule

// File: design/pwi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwi_ctrl
// Sequencer: steps the datapath through multiply, integrate, divide and sum.
// ----------------------------------------------------------------------------
module pwi_ctrl
    import pwi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PRE;
                end
            end
            S_PRE:  state_next = S_MP;
            S_MP:   state_next = S_MI;
            S_MI:   state_next = S_MD;
            S_MD:   state_next = S_AMAG;
            S_AMAG: state_next = S_ILO;
            S_ILO:  state_next = S_IHI;
            S_IHI:  state_next = S_ISUM;
            S_ISUM: state_next = S_DIV;
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_SUM1;
                end
            end
            S_SUM1: state_next = S_SUM2;
            S_SUM2:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.msel = MSEL_ERR_KP;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_PRE:
            begin
                cmd.pre  = 1'b1;
                cmd.msel = MSEL_ERR_KP;
            end
            S_MP:
            begin
                cmd.take_p = 1'b1;
                cmd.msel   = MSEL_ERR_STEP;
            end
            S_MI:
            begin
                cmd.acc_add = 1'b1;
                cmd.msel    = MSEL_DIFF_KD;
            end
            S_MD:
            begin
                cmd.acc_clamp = 1'b1;
                cmd.div_start = 1'b1;
            end
            S_AMAG: cmd.acc_mag = 1'b1;
            S_ILO:  cmd.msel = MSEL_ACC_LO;
            S_IHI:
            begin
                cmd.take_ilo = 1'b1;
                cmd.msel     = MSEL_ACC_HI;
            end
            S_ISUM: cmd.take_isum = 1'b1;
            S_DIV:  ;
            S_SUM1: cmd.sum1 = 1'b1;
            S_SUM2: cmd.load_out = stat.out_free;
            default: ;
        endcase
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pid_with_integral_window_unit. A bit-true model of
// the P, windowed I and D terms predicts each drive beat at input acceptance;
// a monitor compares every output beat in order. Directed tests cover field
// extremes, window edges, inverted window, zero period and an unused register
// index; random phases vary all registers with random idling on both channels,
// and a closing run drives the integral deep negative with no idling.
// ----------------------------------------------------------------------------
module tb_top;
    import pwi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);
    localparam longint DRIVE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint DRIVE_MIN = -DRIVE_MAX - 1;
    localparam longint I_CAP     = 64'sh1000_0000_0000_0000;
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [POS_W-1:0]   measured;
    logic signed [POS_W-1:0]   target;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [DRIVE_W-1:0] drive;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    // shadow registers and loop state
    logic [GAIN_W-1:0]  gain_p = GAIN_RST;
    logic [GAIN_W-1:0]  gain_i = GAIN_RST;
    logic [GAIN_W-1:0]  gain_d = GAIN_RST;
    logic [STEP_W-1:0]  period_ms = STEP_RST;
    logic [WIN_W-1:0]   win_hi = MAXW_RST;
    logic [WIN_W-1:0]   win_lo = MINW_RST;
    logic [LIMIT_W-1:0] integ_limit = LIMIT_RST;
    longint             integ_acc = 0;
    longint             prev_error = 0;

    logic [DRIVE_W-1:0] expected_drive_q[$];
    int                 mismatch_count = 0;
    bit                 quiet_mode = 1'b0;

    pid_with_integral_window_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .measured  (measured),
        .target    (target),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [DRIVE_W-1:0] predict_drive(
        input logic signed [POS_W-1:0] m,
        input logic signed [POS_W-1:0] t
    );
        longint ml, tl, err, aerr, kpl, kil, kdl, stp, whi, wlo, lim;
        longint p_t, i_t, d_t, mag, prod, diff, dmag, dvs, sum;
        ml  = m;
        tl  = t;
        kpl = gain_p;
        kil = gain_i;
        kdl = gain_d;
        stp = period_ms;
        whi = win_hi;
        wlo = win_lo;
        lim = integ_limit;
        err  = tl - ml;
        aerr = (err < 0) ? -err : err;
        p_t  = err * kpl;

        if (aerr > whi || aerr < wlo)
            integ_acc = 0;
        else
        begin
            integ_acc = integ_acc + err * stp;
            if (integ_acc > DRIVE_MAX)
                integ_acc = DRIVE_MAX;
            if (integ_acc < DRIVE_MIN)
                integ_acc = DRIVE_MIN;
        end
        if (integ_acc > lim)
            integ_acc = lim;
        mag = (integ_acc < 0) ? -integ_acc : integ_acc;
        if (kil != 0 && mag > I_CAP / kil)
            prod = I_CAP;
        else
            prod = mag * kil;
        i_t = (integ_acc < 0) ? -prod : prod;

        diff = err - prev_error;
        dvs  = (stp == 0) ? 1 : stp;
        dmag = (((diff < 0) ? -diff : diff) * kdl) / dvs;
        d_t  = (diff < 0) ? -dmag : dmag;
        prev_error = err;

        sum = p_t + i_t + d_t;
        if (sum > DRIVE_MAX)
            sum = DRIVE_MAX;
        if (sum < DRIVE_MIN)
            sum = DRIVE_MIN;
        return sum[DRIVE_W-1:0];
    endfunction

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_sample(input logic signed [POS_W-1:0] m,
                               input logic signed [POS_W-1:0] t);
        if (!quiet_mode && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid = 1'b1;
        measured = m;
        target   = t;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        expected_drive_q.push_back(predict_drive(m, t));
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            REG_KP:    gain_p = data[GAIN_W-1:0];
            REG_KI:    gain_i = data[GAIN_W-1:0];
            REG_KD:    gain_d = data[GAIN_W-1:0];
            REG_STEP:  period_ms = data[STEP_W-1:0];
            REG_MAXW:  win_hi = data[WIN_W-1:0];
            REG_MINW:  win_lo = data[WIN_W-1:0];
            REG_LIMIT: integ_limit = data[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                             input logic [GAIN_W-1:0] d, input logic [STEP_W-1:0] s,
                             input logic [WIN_W-1:0] hi, input logic [WIN_W-1:0] lo,
                             input logic [LIMIT_W-1:0] lim);
        write_reg(REG_KP, CFG_DATA_W'(p));
        write_reg(REG_KI, CFG_DATA_W'(i));
        write_reg(REG_KD, CFG_DATA_W'(d));
        write_reg(REG_STEP, CFG_DATA_W'(s));
        write_reg(REG_MAXW, CFG_DATA_W'(hi));
        write_reg(REG_MINW, CFG_DATA_W'(lo));
        write_reg(REG_LIMIT, CFG_DATA_W'(lim));
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (expected_drive_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // defaults: all gains zero, so drive stays zero
    task automatic test_reset_values();
        send_sample(24'sd0, 24'sd5);
        send_sample(24'sd0, 24'sd20);
        send_sample(24'sd0, 24'sd21);
        wait_idle();
    endtask

    task automatic test_field_extremes();
        write_all('1, '1, '1, '1, '1, '0, '1);
        send_sample(POS_MIN, POS_MAX);
        send_sample(POS_MAX, POS_MIN);
        send_sample(24'sd0, 24'sd0);
        send_sample(POS_MAX, POS_MAX);
        wait_idle();
    endtask

    task automatic test_unused_index();
        write_reg(REG_UNUSED, '1);
        send_sample(-24'sd3, 24'sd1000);
        send_sample(24'sd7, -24'sd7);
        wait_idle();
    endtask

    task automatic test_window_edges();
        write_all(GAIN_W'('h10000), GAIN_W'('h8000), GAIN_W'('h20000), STEP_W'(7),
                  WIN_W'(100), WIN_W'(10), LIMIT_W'(500));
        send_sample(24'sd0, 24'sd9);
        send_sample(24'sd0, 24'sd10);
        send_sample(24'sd0, 24'sd100);
        send_sample(24'sd0, 24'sd101);
        send_sample(24'sd100, 24'sd90);
        send_sample(24'sd100, 24'sd0);
        send_sample(24'sd101, 24'sd0);
        send_sample(24'sd0, 24'sd50);
        send_sample(24'sd0, 24'sd50);
        send_sample(24'sd0, 24'sd50);
        wait_idle();
    endtask

    task automatic test_inverted_window();
        write_reg(REG_MAXW, CFG_DATA_W'(10));
        write_reg(REG_MINW, CFG_DATA_W'(50));
        send_sample(24'sd0, 24'sd20);
        send_sample(24'sd0, 24'sd30);
        send_sample(24'sd0, 24'sd10);
        wait_idle();
    endtask

    task automatic test_zero_period();
        write_all(GAIN_W'('h1234), GAIN_W'('h40000), GAIN_W'('h7FFFFF), STEP_W'(0),
                  WIN_W'(1000), WIN_W'(0), LIMIT_W'(100000));
        send_sample(24'sd0, 24'sd40);
        send_sample(24'sd0, -24'sd40);
        send_sample(24'sd5, 24'sd5);
        wait_idle();
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom_range(0, 'h3FFFF));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    task automatic randomize_config();
        logic [63:0]        noise;
        logic [STEP_W-1:0]  s;
        logic [WIN_W-1:0]   lo;
        logic [WIN_W-1:0]   hi;
        logic [LIMIT_W-1:0] lim;
        noise = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
        case ($urandom_range(0, 4))
            0:       s = '0;
            1:       s = STEP_W'(1);
            2:       s = '1;
            3:       s = STEP_W'(1000);
            default: s = STEP_W'($urandom_range(1, 1023));
        endcase
        case ($urandom_range(0, 5))
            0:
            begin
                lo = WIN_W'($urandom_range(0, 2000));
                hi = WIN_W'($urandom_range(0, 2000));
            end
            1:
            begin
                lo = WIN_W'($urandom);
                hi = WIN_W'($urandom);
            end
            2:
            begin
                lo = '0;
                hi = '1;
            end
            default:
            begin
                lo = WIN_W'($urandom_range(0, 50));
                hi = lo + WIN_W'($urandom_range(0, 3000));
            end
        endcase
        case ($urandom_range(0, 3))
            0:       lim = '0;
            1:       lim = '1;
            2:       lim = LIMIT_W'({$urandom, $urandom});
            default: lim = LIMIT_W'($urandom_range(0, 1000000));
        endcase
        write_reg(REG_KP, {noise[15:0], pick_gain()});
        write_reg(REG_KI, {noise[31:16], pick_gain()});
        write_reg(REG_KD, {noise[47:32], pick_gain()});
        write_reg(REG_STEP, {noise[29:0], s});
        write_reg(REG_MAXW, {noise[63:48], hi});
        write_reg(REG_MINW, {noise[55:40], lo});
        write_reg(REG_LIMIT, lim);
        if ($urandom_range(0, 5) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
    endtask

    task automatic test_random_traffic();
        logic signed [POS_W-1:0] m;
        logic signed [POS_W-1:0] t;
        longint                  span;
        longint                  off;
        for (int phase = 0; phase < 10; phase++)
        begin
            randomize_config();
            for (int n = 0; n < 50; n++)
            begin
                m = POS_W'($urandom);
                if ($urandom_range(0, 9) < 7)
                begin
                    span = (win_hi < 4000) ? longint'(win_hi) + 8
                                           : longint'($urandom_range(0, 4000));
                    off  = longint'($urandom_range(0, int'(2 * span))) - span;
                    t    = POS_W'(longint'(m) + off);
                end
                else
                    t = POS_W'($urandom);
                send_sample(m, t);
            end
            wait_idle();
        end
    endtask

    // back-to-back beats with no idling: integral runs deep negative, then climbs back toward zero
    task automatic test_back_to_back();
        quiet_mode = 1'b1;
        write_all('0, GAIN_W'(1), '0, '1, '1, '0, '1);
        for (int n = 0; n < 24; n++)
            send_sample(POS_MAX, POS_MIN);
        for (int n = 0; n < 4; n++)
            send_sample(POS_MIN, POS_MAX);
        wait_idle();
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (!quiet_mode && $urandom_range(0, 2) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            out_ready = 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : check_drive
        logic [DRIVE_W-1:0] want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (expected_drive_q.size() == 0)
            begin
                $display("%0t drive beat with nothing pending: expected none, actual %0d",
                         $time, drive);
                mismatch_count++;
            end
            else
            begin
                want = expected_drive_q.pop_front();
                if (drive !== want)
                begin
                    $display("%0t drive mismatch: expected %0d, actual %0d",
                             $time, $signed(want), drive);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        measured  = '0;
        target    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_values();
        test_field_extremes();
        test_unused_index();
        test_window_edges();
        test_inverted_window();
        test_zero_period();
        test_random_traffic();
        test_back_to_back();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
